FILE: design/hecs_pkg.sv
// ----------------------------------------------------------------------------
// hecs_pkg
// Shared types, constants and helper functions of the hybrid entropy coder
// statistics unit.
// ----------------------------------------------------------------------------
package hecs_pkg;

    // Band statistics store
    localparam int BANDS   = 256;
    localparam int ADDR_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CNT_W   = 12;
    localparam int ACC_W   = 48;
    localparam int STAT_W  = CNT_W + ACC_W;

    // Job queue between front and back (depth kept a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] CFG_DYNAMIC_RANGE          = 3'd0;
    localparam logic [2:0] CFG_INITIAL_COUNT_EXPONENT = 3'd1;
    localparam logic [2:0] CFG_INITIAL_ACCUMULATOR    = 3'd2;
    localparam logic [2:0] CFG_COUNT_LIMIT_EXPONENT   = 3'd3;
    localparam logic [2:0] CFG_UNARY_LIMIT            = 3'd4;

    // Result kinds and special symbols
    localparam logic       KIND_CHUNK  = 1'b0;
    localparam logic       KIND_REPORT = 1'b1;
    localparam logic [4:0] SYM_ESCAPE  = 5'd16;
    localparam logic       OP_ENCODE   = 1'b0;
    localparam logic       OP_DUMP     = 1'b1;

    // Low-entropy code thresholds and symbol limits
    localparam logic [18:0] ENT_THR [16] = '{
        19'd303336, 19'd225404, 19'd166979, 19'd128672,
        19'd95597,  19'd69670,  19'd50678,  19'd34898,
        19'd23331,  19'd14935,  19'd9282,   19'd5510,
        19'd3195,   19'd1928,   19'd1112,   19'd408
    };
    localparam logic [3:0] SYM_LIM [16] = '{
        4'd12, 4'd10, 4'd8, 4'd6, 4'd6, 4'd4, 4'd4, 4'd4,
        4'd2,  4'd2,  4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd0
    };

    typedef struct packed {
        logic [5:0]  dynamic_range;
        logic [3:0]  initial_count_exponent;
        logic [31:0] initial_accumulator;
        logic [3:0]  count_limit_exponent;
        logic [5:0]  unary_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_DUMP,
        JOB_RAW,
        JOB_CODE
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic               rescale;
        logic               rescale_bit;
        logic [31:0]        sample;
        logic [ACC_W-1:0]   acc;
        logic [CNT_W-1:0]   cnt;
    } job_t;

    typedef struct packed {
        logic [63:0] bits;
        logic [6:0]  count;
    } chunk_t;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DISPATCH,
        B_KSEARCH,
        B_HIEMIT,
        B_ISEARCH,
        B_LOEVAL,
        B_REPORT
    } back_state_t;

    // Clamped register values
    function automatic logic [5:0] eff_d(cfg_t c);
        if (c.dynamic_range < 6'd2)
            return 6'd2;
        else if (c.dynamic_range > 6'd32)
            return 6'd32;
        else
            return c.dynamic_range;
    endfunction

    function automatic logic [3:0] eff_gs(cfg_t c);
        if (c.count_limit_exponent < 4'd4)
            return 4'd4;
        else if (c.count_limit_exponent > 4'd11)
            return 4'd11;
        else
            return c.count_limit_exponent;
    endfunction

    function automatic logic [3:0] eff_ice(cfg_t c);
        if (c.initial_count_exponent < 4'd1)
            return 4'd1;
        else if (c.initial_count_exponent > 4'd8)
            return 4'd8;
        else
            return c.initial_count_exponent;
    endfunction

    function automatic logic [5:0] eff_umax(cfg_t c);
        if (c.unary_limit < 6'd8)
            return 6'd8;
        else if (c.unary_limit > 6'd32)
            return 6'd32;
        else
            return c.unary_limit;
    endfunction

    function automatic logic [63:0] low_bits(logic [63:0] v, logic [6:0] n);
        if (n >= 7'd64)
            return v;
        else
            return v & ((64'd1 << n) - 64'd1);
    endfunction

    // Length-limited GPO2 codeword of v with parameter k
    function automatic chunk_t gpo2(logic [31:0] v, logic [4:0] k,
                                    logic [5:0] d, logic [5:0] umax);
        logic [31:0] u;
        chunk_t      c;
        u = v >> k;
        if (u < {26'd0, umax}) begin
            c.bits  = (low_bits({32'd0, v}, {2'd0, k}) << ({1'b0, u[4:0]} + 6'd1))
                    | (64'd1 << u[4:0]);
            c.count = {2'd0, k} + 7'd1 + {2'd0, u[4:0]};
        end else begin
            c.bits  = low_bits({32'd0, v}, {1'b0, d}) << umax;
            c.count = {1'b0, d} + {1'b0, umax};
        end
        return c;
    endfunction

endpackage

FILE: design/hecs_ram.sv
// ----------------------------------------------------------------------------
// hecs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hecs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/hecs_front.sv
// ----------------------------------------------------------------------------
// hecs_front
// Accepts input transactions, updates the per-band statistics of encode
// transactions and hands a classified job to the queue.
// ----------------------------------------------------------------------------
module hecs_front
    import hecs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] sample,
    input  logic [7:0]  band,
    input  logic        first_in_band,
    output logic        push,
    output job_t        push_job,
    input  logic        full
);

    front_state_t state_reg, state_next;
    logic         op_reg;
    logic [31:0]  sample_reg;
    logic [7:0]   band_reg;
    logic         first_reg;
    logic         range_reg;

    logic               accept;
    logic               in_range;
    logic               wr_en;
    logic [STAT_W-1:0]  wr_data;
    logic [STAT_W-1:0]  rd_data;
    logic [CNT_W-1:0]   cnt_old, cnt_new, limit;
    logic [ACC_W-1:0]   acc_old, acc_new;
    logic [ACC_W:0]     sum, sum_r;
    logic [CNT_W:0]     cnt_inc;
    logic [3:0]         gs, ice;
    logic               rescale;

    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(band) < 32'(BANDS));

    hecs_ram #(
        .WIDTH (STAT_W),
        .DEPTH (BANDS)
    ) u_stats (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(band_reg)),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(band)),
        .rd_data (rd_data)
    );

    // Statistics update
    always_comb
    begin
        gs      = eff_gs(cfg);
        ice     = eff_ice(cfg);
        cnt_old = rd_data[STAT_W-1:ACC_W];
        acc_old = rd_data[ACC_W-1:0];
        limit   = (CNT_W'(1) << gs) - CNT_W'(1);
        sum     = {1'b0, acc_old} + {15'd0, sample_reg, 2'b00};
        sum_r   = sum + 49'd1;
        cnt_inc = {1'b0, cnt_old} + 13'd1;
        rescale = 1'b0;
        if (first_reg) begin
            cnt_new = CNT_W'(1) << ice;
            acc_new = ACC_W'(cfg.initial_accumulator);
        end else if (cnt_old < limit) begin
            cnt_new = cnt_inc[CNT_W-1:0];
            acc_new = sum[ACC_W-1:0];
        end else begin
            rescale = 1'b1;
            cnt_new = cnt_inc[CNT_W:1];
            acc_new = sum_r[ACC_W:1];
        end
        wr_data = {cnt_new, acc_new};

        push_job.rescale     = 1'b0;
        push_job.rescale_bit = acc_old[0];
        push_job.sample      = sample_reg;
        if (op_reg == OP_DUMP) begin
            push_job.kind = JOB_DUMP;
            push_job.acc  = acc_old;
            push_job.cnt  = cnt_old;
        end else if (first_reg) begin
            push_job.kind = JOB_RAW;
            push_job.acc  = acc_new;
            push_job.cnt  = cnt_new;
        end else begin
            push_job.kind    = JOB_CODE;
            push_job.rescale = rescale;
            push_job.acc     = acc_new;
            push_job.cnt     = (cnt_new == '0) ? CNT_W'(1) : cnt_new;
        end
    end

    // Next state and handoff
    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        wr_en      = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_UPD;
            end
            F_UPD:
            begin
                if (!range_reg) begin
                    state_next = F_IDLE;
                end else if (!full) begin
                    push       = 1'b1;
                    wr_en      = (op_reg != OP_DUMP);
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Captured input fields
    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_reg     <= operation;
            sample_reg <= sample;
            band_reg   <= band;
            first_reg  <= first_in_band;
            range_reg  <= in_range;
        end
    end

endmodule

FILE: design/hecs_queue.sv
// ----------------------------------------------------------------------------
// hecs_queue
// Short job queue that decouples the statistics front from the coder back.
// ----------------------------------------------------------------------------
module hecs_queue
    import hecs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: design/hecs_back.sv
// ----------------------------------------------------------------------------
// hecs_back
// Takes jobs from the queue, selects the code of coded jobs by iterative
// search and drives the output register.
// ----------------------------------------------------------------------------
module hecs_back
    import hecs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  job_t        head_job,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [63:0] bits,
    output logic [6:0]  bit_count,
    output logic [3:0]  code_index,
    output logic [4:0]  symbol,
    output logic        last
);

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [4:0]  j_reg, j_next;
    logic [4:0]  kk_reg, kk_next;
    logic [3:0]  idx_reg, idx_next;
    logic [48:0] v_reg, v_next;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [63:0] bits_reg;
    logic [6:0]  count_reg;
    logic [3:0]  cidx_reg;
    logic [4:0]  sym_reg;
    logic        last_reg;

    logic        emit;
    logic        e_kind, e_last;
    logic [63:0] e_bits;
    logic [6:0]  e_count;
    logic [3:0]  e_idx;
    logic [4:0]  e_sym;

    logic [5:0]  d, umax;
    logic [3:0]  gs;
    logic [6:0]  dump_w;
    logic        out_free;
    logic [61:0] acc14;
    logic [18:0] thr;
    logic [30:0] prod;
    logic        q_ge;
    logic [49:0] shifted;
    logic        k_ok;
    logic [3:0]  lim;
    logic [31:0] esc_r;
    chunk_t      code_chunk;
    logic [17:0] cnt49;

    // Shared datapath
    always_comb
    begin
        d        = eff_d(cfg);
        umax     = eff_umax(cfg);
        gs       = eff_gs(cfg);
        dump_w   = {1'b0, d} + {3'd0, gs} + 7'd2;
        out_free = !out_valid_reg || out_ready;
        acc14    = {job_reg.acc, 14'd0};
        thr      = (state_reg == B_DISPATCH) ? ENT_THR[0] : ENT_THR[j_reg[3:0]];
        prod     = 31'(thr) * 31'(job_reg.cnt);
        q_ge     = (acc14 >= 62'(prod));
        shifted  = 50'(job_reg.cnt) << ({1'b0, j_reg} + 6'd2);
        k_ok     = (shifted <= {1'b0, v_reg});
        lim      = SYM_LIM[idx_reg];
        esc_r    = job_reg.sample - 32'(lim) - 32'd1;
        cnt49    = 18'(job_reg.cnt) * 18'd49;
        if (state_reg == B_HIEMIT)
            code_chunk = gpo2(job_reg.sample, kk_reg, d, umax);
        else
            code_chunk = gpo2(esc_r, 5'd0, d, umax);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        j_next     = j_reg;
        kk_next    = kk_reg;
        idx_next   = idx_reg;
        v_next     = v_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        e_kind     = KIND_CHUNK;
        e_bits     = '0;
        e_count    = '0;
        e_idx      = '0;
        e_sym      = '0;
        e_last     = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty) begin
                    pop        = 1'b1;
                    job_next   = head_job;
                    state_next = B_DISPATCH;
                end
            end
            B_DISPATCH:
            begin
                unique case (job_reg.kind)
                    JOB_DUMP:
                    begin
                        if (out_free) begin
                            emit       = 1'b1;
                            e_bits     = (low_bits({16'd0, job_reg.acc}, dump_w) << 1)
                                       | 64'd1;
                            e_count    = dump_w + 7'd1;
                            e_last     = 1'b1;
                            state_next = B_IDLE;
                        end
                    end
                    JOB_RAW:
                    begin
                        if (out_free) begin
                            emit       = 1'b1;
                            e_bits     = low_bits({32'd0, job_reg.sample}, {1'b0, d});
                            e_count    = {1'b0, d};
                            e_last     = 1'b1;
                            state_next = B_IDLE;
                        end
                    end
                    JOB_CODE:
                    begin
                        if (job_reg.rescale) begin
                            // pending rescale bit goes out first
                            if (out_free) begin
                                emit             = 1'b1;
                                e_bits           = {63'd0, job_reg.rescale_bit};
                                e_count          = 7'd1;
                                job_next.rescale = 1'b0;
                            end
                        end else begin
                            v_next = {1'b0, job_reg.acc} + 49'(cnt49[17:5]);
                            if (q_ge) begin
                                j_next     = 5'd0;
                                kk_next    = 5'd0;
                                state_next = B_KSEARCH;
                            end else begin
                                j_next     = 5'd1;
                                idx_next   = 4'd0;
                                state_next = B_ISEARCH;
                            end
                        end
                    end
                    default: state_next = B_IDLE;
                endcase
            end
            B_KSEARCH:
            begin
                // one candidate shift per cycle
                if (k_ok)
                    kk_next = j_reg;
                if (j_reg == 5'(d - 6'd2))
                    state_next = B_HIEMIT;
                else
                    j_next = j_reg + 5'd1;
            end
            B_HIEMIT:
            begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_bits     = code_chunk.bits;
                    e_count    = code_chunk.count;
                    e_last     = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_ISEARCH:
            begin
                // one threshold per cycle on the shared multiplier
                if (!q_ge)
                    idx_next = j_reg[3:0];
                if (j_reg == 5'd15)
                    state_next = B_LOEVAL;
                else
                    j_next = j_reg + 5'd1;
            end
            B_LOEVAL:
            begin
                if (out_free) begin
                    emit = 1'b1;
                    if (job_reg.sample > 32'(lim)) begin
                        e_bits     = code_chunk.bits;
                        e_count    = code_chunk.count;
                        state_next = B_REPORT;
                    end else begin
                        e_kind     = KIND_REPORT;
                        e_idx      = idx_reg;
                        e_sym      = job_reg.sample[4:0];
                        e_last     = 1'b1;
                        state_next = B_IDLE;
                    end
                end
            end
            B_REPORT:
            begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = KIND_REPORT;
                    e_idx      = idx_reg;
                    e_sym      = SYM_ESCAPE;
                    e_last     = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        j_reg   <= j_next;
        kk_reg  <= kk_next;
        idx_reg <= idx_next;
        v_reg   <= v_next;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (emit) begin
            kind_reg  <= e_kind;
            bits_reg  <= e_bits;
            count_reg <= e_count;
            cidx_reg  <= e_idx;
            sym_reg   <= e_sym;
            last_reg  <= e_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign bits       = bits_reg;
    assign bit_count  = count_reg;
    assign code_index = cidx_reg;
    assign symbol     = sym_reg;
    assign last       = last_reg;

endmodule

FILE: design/hybrid_entropy_coder_stats_unit.sv
// Flow: the front takes a new input transaction while the back still codes
// earlier items, until the job queue is full; the work per coded item is set
// by the code search in the back (one shift compare per cycle over up to D-1
// candidates, or 15 thresholds).
// Reset: control state cleared, registers to defaults; band statistics RAM is
// not cleared, a band is defined by its first sample.
// ----------------------------------------------------------------------------
// hybrid_entropy_coder_stats_unit
// Top level: configuration registers, statistics front, job queue, coder back.
// ----------------------------------------------------------------------------
module hybrid_entropy_coder_stats_unit
    import hecs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] sample,
    input  logic [7:0]  band,
    input  logic        first_in_band,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [63:0] bits,
    output logic [6:0]  bit_count,
    output logic [3:0]  code_index,
    output logic [4:0]  symbol,
    output logic        last
);

    cfg_t cfg_reg;
    logic push, pop, full, empty;
    job_t push_job, head_job;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.dynamic_range          <= 6'd16;
            cfg_reg.initial_count_exponent <= 4'd1;
            cfg_reg.initial_accumulator    <= 32'd0;
            cfg_reg.count_limit_exponent   <= 4'd6;
            cfg_reg.unary_limit            <= 6'd18;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DYNAMIC_RANGE:          cfg_reg.dynamic_range <= cfg_data[5:0];
                CFG_INITIAL_COUNT_EXPONENT: cfg_reg.initial_count_exponent <= cfg_data[3:0];
                CFG_INITIAL_ACCUMULATOR:    cfg_reg.initial_accumulator <= cfg_data;
                CFG_COUNT_LIMIT_EXPONENT:   cfg_reg.count_limit_exponent <= cfg_data[3:0];
                CFG_UNARY_LIMIT:            cfg_reg.unary_limit <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    hecs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .sample        (sample),
        .band          (band),
        .first_in_band (first_in_band),
        .push          (push),
        .push_job      (push_job),
        .full          (full)
    );

    hecs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (head_job),
        .empty    (empty)
    );

    hecs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_job   (head_job),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .bits       (bits),
        .bit_count  (bit_count),
        .code_index (code_index),
        .symbol     (symbol),
        .last       (last)
    );

endmodule

FILE: design/hecs_checker.sv
// ----------------------------------------------------------------------------
// hecs_checker
// Port-level checks on the result channel of the statistics unit.
// ----------------------------------------------------------------------------
module hecs_checker
    import hecs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic [63:0] bits,
    input logic [6:0]  bit_count,
    input logic [3:0]  code_index,
    input logic [4:0]  symbol,
    input logic        last
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bits) && $stable(kind)
        && $stable(last))
        else $error("result changed while stalled");

    // Symbol report carries no chunk and closes its item
    a_report_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_REPORT) |-> bits == 64'd0 && bit_count == 7'd0
        && last && symbol <= SYM_ESCAPE)
        else $error("malformed symbol report");

    // Chunk has a length and no report fields
    a_chunk_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CHUNK) |-> bit_count != 7'd0
        && bit_count <= 7'd64 && code_index == 4'd0 && symbol == 5'd0)
        else $error("malformed chunk");

    // A partial chunk is not followed by an empty chunk
    a_escape_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind == KIND_CHUNK) && !last
        |=> !(out_valid && kind == KIND_CHUNK && bit_count == 7'd0))
        else $error("empty chunk after partial result");

endmodule

bind hybrid_entropy_coder_stats_unit hecs_checker u_hecs_checker (.*);
